FILE: sv/ccsc_pkg.sv
// Shared types, constants and helpers for the cartesian cell to simplex block.
package ccsc_pkg;

	localparam int unsigned MAX_AXIS_POINTS = 1024;

	localparam int CNT_W   = 11;  // point count per axis
	localparam int IDX_W   = 10;  // cell index per axis
	localparam int NINJ_W  = 21;  // points_i * points_j
	localparam int PROD1_W = 20;  // u*(nv-1) + w
	localparam int PROD2_W = 30;  // linear cell index
	localparam int NODE_W  = 31;
	localparam int ELEM_W  = 33;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// element kinds as seen on the result channel
	localparam logic [1:0] KIND_BAR = 2'd0;
	localparam logic [1:0] KIND_TRI = 2'd1;
	localparam logic [1:0] KIND_TET = 2'd2;

	// axis codes: flat axis for triangles, line axis for bars
	localparam logic [1:0] AX_I = 2'd0;
	localparam logic [1:0] AX_J = 2'd1;
	localparam logic [1:0] AX_K = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_POINTS_I = 2'd0;
	localparam logic [1:0] REG_POINTS_J = 2'd1;
	localparam logic [1:0] REG_POINTS_K = 2'd2;

	// grid geometry shared by front and back
	typedef struct packed {
		logic [CNT_W-1:0]  ni;
		logic [NINJ_W-1:0] ninj;
	} geom_t;

	// one classified cell, ready to be expanded into elements
	typedef struct packed {
		logic              bad;
		logic [1:0]        kind;
		logic [1:0]        axis;
		logic              parity;
		logic [NODE_W-1:0] base_node;
		logic [ELEM_W-1:0] base_elem;
	} job_t;

	// counts above the supported maximum saturate
	function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v);
		if (v > CNT_W'(MAX_AXIS_POINTS))
			return CNT_W'(MAX_AXIS_POINTS);
		return v;
	endfunction

endpackage

FILE: sv/ccsc_front.sv
// Front part: accepts cells, checks them against the grid, forms base node and element.
module ccsc_front import ccsc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CNT_W-1:0]  points_i,
	input  logic [CNT_W-1:0]  points_j,
	input  logic [CNT_W-1:0]  points_k,
	input  logic              cell_valid,
	output logic              cell_ready,
	input  logic [IDX_W-1:0]  cell_i,
	input  logic [IDX_W-1:0]  cell_j,
	input  logic [IDX_W-1:0]  cell_k,
	output logic              job_valid,
	output job_t              job,
	input  logic              q_full,
	output geom_t             geom
);

	logic adv;

	// stage 1: captured cell
	logic             v_s1;
	logic [IDX_W-1:0] i_s1, j_s1, k_s1;

	// stage 2: classification and first products
	logic               v_s2, bad_s2, par_s2;
	logic [1:0]         kind_s2, axis_s2;
	logic [IDX_W-1:0]   i_s2, k_s2, mi_s2;
	logic [PROD1_W-1:0] first_s2;
	logic [NINJ_W-1:0]  jni_s2;

	// stage 3: second products
	logic               v_s3, bad_s3, par_s3;
	logic [1:0]         kind_s3, axis_s3;
	logic [IDX_W-1:0]   i_s3;
	logic [NINJ_W-1:0]  jni_s3;
	logic [NODE_W-1:0]  kninj_s3;
	logic [PROD2_W-1:0] second_s3;

	geom_t geom_q;

	logic [CNT_W-1:0]   ni, nj, nk, ni_m1, nj_m1, nk_m1;
	logic               fi, fj, fk, in_i, in_j, in_k, ok, swap;
	logic [1:0]         nflat, kind_c, axis_c;
	logic [IDX_W-1:0]   mi, mj, u, mv, w;
	logic [PROD1_W-1:0] first_c;
	logic [NINJ_W-1:0]  jni_c;
	logic [NODE_W-1:0]  kninj_c;
	logic [PROD2_W-1:0] second_c;

	// whole pipeline moves unless the last stage is blocked by a full queue
	assign adv        = !v_s3 || !q_full;
	assign cell_ready = adv;

	// grid geometry, refreshed every cycle from the registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q.ni   <= CNT_W'(2);
			geom_q.ninj <= NINJ_W'(4);
		end else begin
			geom_q.ni   <= clamp_count(points_i);
			geom_q.ninj <= NINJ_W'(clamp_count(points_i)) * NINJ_W'(clamp_count(points_j));
		end
	end
	assign geom = geom_q;

	// stage 1 capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (adv)
			v_s1 <= cell_valid;
	end
	always_ff @(posedge clk) begin
		if (adv && cell_valid) begin
			i_s1 <= cell_i;
			j_s1 <= cell_j;
			k_s1 <= cell_k;
		end
	end

	// classify the cell against the grid
	always_comb begin
		ni    = clamp_count(points_i);
		nj    = clamp_count(points_j);
		nk    = clamp_count(points_k);
		ni_m1 = ni - CNT_W'(1);
		nj_m1 = nj - CNT_W'(1);
		nk_m1 = nk - CNT_W'(1);
		fi    = (ni == CNT_W'(1));
		fj    = (nj == CNT_W'(1));
		fk    = (nk == CNT_W'(1));
		nflat = {1'b0, fi} + {1'b0, fj} + {1'b0, fk};
		in_i  = fi ? (i_s1 == '0) : (({1'b0, i_s1} + CNT_W'(1)) < ni);
		in_j  = fj ? (j_s1 == '0) : (({1'b0, j_s1} + CNT_W'(1)) < nj);
		in_k  = fk ? (k_s1 == '0) : (({1'b0, k_s1} + CNT_W'(1)) < nk);
		ok    = (ni != '0) && (nj != '0) && (nk != '0) && (nflat != 2'd3)
		        && in_i && in_j && in_k;

		if (nflat == 2'd0)
			kind_c = KIND_TET;
		else if (nflat == 2'd1)
			kind_c = KIND_TRI;
		else
			kind_c = KIND_BAR;

		if (nflat == 2'd1)
			axis_c = fk ? AX_K : (fj ? AX_J : AX_I);
		else
			axis_c = !fi ? AX_I : (!fj ? AX_J : AX_K);

		// flat axes count as one cell wide in the linear cell index
		mi = fi ? IDX_W'(1) : ni_m1[IDX_W-1:0];
		mj = fj ? IDX_W'(1) : nj_m1[IDX_W-1:0];

		// triangles with the first axis flat number j-major over k
		swap = fi && (nflat == 2'd1);
		u    = swap ? j_s1 : k_s1;
		mv   = swap ? nk_m1[IDX_W-1:0] : mj;
		w    = swap ? k_s1 : j_s1;

		first_c = PROD1_W'(u) * PROD1_W'(mv) + PROD1_W'(w);
		jni_c   = NINJ_W'(j_s1) * NINJ_W'(ni);
	end

	// stage 2 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (adv)
			v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			bad_s2   <= !ok;
			par_s2   <= i_s1[0] ^ j_s1[0] ^ k_s1[0];
			kind_s2  <= kind_c;
			axis_s2  <= axis_c;
			i_s2     <= i_s1;
			k_s2     <= k_s1;
			mi_s2    <= mi;
			first_s2 <= first_c;
			jni_s2   <= jni_c;
		end
	end

	// second products
	assign kninj_c  = NODE_W'(k_s2) * NODE_W'(geom_q.ninj);
	assign second_c = PROD2_W'(first_s2) * PROD2_W'(mi_s2) + PROD2_W'(i_s2);

	// stage 3 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (adv)
			v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (adv && v_s2) begin
			bad_s3    <= bad_s2;
			par_s3    <= par_s2;
			kind_s3   <= kind_s2;
			axis_s3   <= axis_s2;
			i_s3      <= i_s2;
			jni_s3    <= jni_s2;
			kninj_s3  <= kninj_c;
			second_s3 <= second_c;
		end
	end

	// job for the queue: base node and first element number
	always_comb begin
		job.bad       = bad_s3;
		job.kind      = kind_s3;
		job.axis      = axis_s3;
		job.parity    = par_s3;
		job.base_node = NODE_W'(1) + NODE_W'(i_s3) + NODE_W'(jni_s3) + kninj_s3;
		case (kind_s3)
			KIND_TET: job.base_elem = (ELEM_W'(second_s3) << 2) + ELEM_W'(second_s3);
			KIND_TRI: job.base_elem = ELEM_W'(second_s3) << 1;
			default:  job.base_elem = ELEM_W'(second_s3);
		endcase
	end
	assign job_valid = v_s3;

endmodule

FILE: sv/ccsc_queue.sv
// Short job queue between the front and back parts.
module ccsc_queue import ccsc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	input  job_t wr_job,
	output logic full,
	output logic head_valid,
	output job_t head,
	input  logic pop
);

	job_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push, take;

	assign full       = (count_q == QCNT_W'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slot_q[rd_ptr_q];
	assign push       = wr_valid && !full;
	assign take       = pop && head_valid;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (take)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !take)
				count_q <= count_q + QCNT_W'(1);
			else if (take && !push)
				count_q <= count_q - QCNT_W'(1);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= wr_job;
	end

endmodule

FILE: sv/ccsc_back.sv
// Back part: expands one job into its elements through the output register.
module ccsc_back import ccsc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  job_t               head,
	input  geom_t              geom,
	output logic               pop,
	output logic               elem_valid,
	input  logic               elem_ready,
	output logic [ELEM_W-1:0]  element_number,
	output logic [NODE_W-1:0]  node_a,
	output logic [NODE_W-1:0]  node_b,
	output logic [NODE_W-1:0]  node_c,
	output logic [NODE_W-1:0]  node_d,
	output logic [1:0]         element_kind,
	output logic               last_of_cell,
	output logic               bad_cell
);

	logic              ov_q, last_q, bad_q;
	logic [2:0]        idx_q, last_idx;
	logic [1:0]        kind_q;
	logic [ELEM_W-1:0] elem_q;
	logic [NODE_W-1:0] na_q, nb_q, nc_q, nd_q;
	logic              load, fire, at_last;
	logic [NODE_W-1:0] ca, cb, cc, cd, ce, cf, cg, ch;
	logic [NODE_W-1:0] p1, p2, p3, p4;
	logic [NODE_W-1:0] na, nb, nc, nd;

	assign load    = !ov_q || elem_ready;
	assign fire    = head_valid && load;
	assign at_last = (idx_q == last_idx);
	assign pop     = fire && at_last;

	// index of the final element for this job
	always_comb begin
		if (head.bad)
			last_idx = 3'd0;
		else if (head.kind == KIND_TET)
			last_idx = 3'd4;
		else if (head.kind == KIND_TRI)
			last_idx = 3'd1;
		else
			last_idx = 3'd0;
	end

	// cube corners around the base node
	always_comb begin
		ca = head.base_node;
		cb = ca + NODE_W'(1);
		cd = ca + NODE_W'(geom.ni);
		cc = cd + NODE_W'(1);
		ce = ca + NODE_W'(geom.ninj);
		cf = ce + NODE_W'(1);
		ch = ce + NODE_W'(geom.ni);
		cg = ch + NODE_W'(1);
	end

	// triangle corners by flat axis
	always_comb begin
		unique case (head.axis)
			AX_K: begin
				p1 = ca; p2 = cb; p3 = cc; p4 = cd;
			end
			AX_J: begin
				p1 = ca; p2 = ce; p3 = cf; p4 = cb;
			end
			default: begin
				p1 = ca; p2 = cd; p3 = ch; p4 = ce;
			end
		endcase
	end

	// node selection for the current element
	always_comb begin
		na = '0;
		nb = '0;
		nc = '0;
		nd = '0;
		if (!head.bad) begin
			unique case (head.kind)
				KIND_TET: begin
					if (!head.parity) begin
						unique case (idx_q)
							3'd0: begin na = ca; nb = cb; nc = cd; nd = ce; end
							3'd1: begin na = cb; nb = cc; nc = cd; nd = cg; end
							3'd2: begin na = cd; nb = ce; nc = cg; nd = ch; end
							3'd3: begin na = cb; nb = ce; nc = cf; nd = cg; end
							3'd4: begin na = cb; nb = cd; nc = ce; nd = cg; end
							default: ;
						endcase
					end else begin
						unique case (idx_q)
							3'd0: begin na = ca; nb = cc; nc = cd; nd = ch; end
							3'd1: begin na = ca; nb = cf; nc = cb; nd = cc; end
							3'd2: begin na = ch; nb = cg; nc = cf; nd = cc; end
							3'd3: begin na = cf; nb = ch; nc = ca; nd = ce; end
							3'd4: begin na = cf; nb = ca; nc = ch; nd = cc; end
							default: ;
						endcase
					end
				end
				KIND_TRI: begin
					na = p1;
					nb = (idx_q == 3'd0) ? p2 : p3;
					nc = (idx_q == 3'd0) ? p3 : p4;
				end
				KIND_BAR: begin
					na = ca;
					nb = (head.axis == AX_I) ? cb : ((head.axis == AX_J) ? cd : ce);
				end
				default: ;
			endcase
		end
	end

	// control: output valid and element counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q  <= 1'b0;
			idx_q <= '0;
		end else begin
			if (load)
				ov_q <= head_valid;
			if (fire)
				idx_q <= at_last ? 3'd0 : idx_q + 3'd1;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (fire) begin
			elem_q <= head.bad ? '0 : head.base_elem + ELEM_W'(idx_q);
			na_q   <= na;
			nb_q   <= nb;
			nc_q   <= nc;
			nd_q   <= nd;
			kind_q <= head.bad ? KIND_BAR : head.kind;
			last_q <= at_last;
			bad_q  <= head.bad;
		end
	end

	assign elem_valid     = ov_q;
	assign element_number = elem_q;
	assign node_a         = na_q;
	assign node_b         = nb_q;
	assign node_c         = nc_q;
	assign node_d         = nd_q;
	assign element_kind   = kind_q;
	assign last_of_cell   = last_q;
	assign bad_cell       = bad_q;

	// a cell never yields more than five elements
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= 3'd4)
		else $error("element counter out of range");

	// counter steps by one inside a cell
	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !at_last |=> idx_q == $past(idx_q) + 3'd1)
		else $error("element counter skipped");

	// a flagged cell is a single all-zero result
	a_bad_result: assert property (@(posedge clk) disable iff (!arst_n)
		elem_valid && bad_cell |-> last_of_cell && element_number == '0
		&& node_a == '0 && node_b == '0)
		else $error("bad cell result malformed");

	// a bar closes its cell at once
	a_bar_last: assert property (@(posedge clk) disable iff (!arst_n)
		elem_valid && element_kind == KIND_BAR |-> last_of_cell)
		else $error("bar element not last of cell");

endmodule

FILE: sv/cartesian_cell_to_simplex_connectivity.sv
// Top level: configuration registers, front part, job queue and back part.
//
//  transaction  | handshake                | payload
//  -------------+--------------------------+-------------------------------------------
//  cell in      | cell_valid / cell_ready  | cell_i, cell_j, cell_k
//  element out  | elem_valid / elem_ready  | element_number, node_a..node_d,
//               |                          | element_kind, last_of_cell, bad_cell
//  config write | cfg_we                   | cfg_index, cfg_data
//
// A tetrahedral cell yields five elements, a triangle cell two, a bar or flagged cell one:
// the back part sends one element per cycle through a single output register while
// elem_ready is high. A cell passes three front stages and the queue before that register.
// The front keeps taking cells while the four-entry queue has room, so it runs ahead of
// output stalls. Reset is asynchronous; counts reset to 2, no memory needs clearing.
module cartesian_cell_to_simplex_connectivity import ccsc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [CNT_W-1:0]   cfg_data,
	input  logic               cell_valid,
	output logic               cell_ready,
	input  logic [IDX_W-1:0]   cell_i,
	input  logic [IDX_W-1:0]   cell_j,
	input  logic [IDX_W-1:0]   cell_k,
	output logic               elem_valid,
	input  logic               elem_ready,
	output logic [ELEM_W-1:0]  element_number,
	output logic [NODE_W-1:0]  node_a,
	output logic [NODE_W-1:0]  node_b,
	output logic [NODE_W-1:0]  node_c,
	output logic [NODE_W-1:0]  node_d,
	output logic [1:0]         element_kind,
	output logic               last_of_cell,
	output logic               bad_cell
);

	logic [CNT_W-1:0] points_i_q, points_j_q, points_k_q;
	logic             job_valid, q_full, head_valid, pop;
	job_t             job, head;
	geom_t            geom;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_i_q <= CNT_W'(2);
			points_j_q <= CNT_W'(2);
			points_k_q <= CNT_W'(2);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POINTS_I: points_i_q <= cfg_data;
				REG_POINTS_J: points_j_q <= cfg_data;
				REG_POINTS_K: points_k_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ccsc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.points_i   (points_i_q),
		.points_j   (points_j_q),
		.points_k   (points_k_q),
		.cell_valid (cell_valid),
		.cell_ready (cell_ready),
		.cell_i     (cell_i),
		.cell_j     (cell_j),
		.cell_k     (cell_k),
		.job_valid  (job_valid),
		.job        (job),
		.q_full     (q_full),
		.geom       (geom)
	);

	ccsc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_valid   (job_valid),
		.wr_job     (job),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	ccsc_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_valid     (head_valid),
		.head           (head),
		.geom           (geom),
		.pop            (pop),
		.elem_valid     (elem_valid),
		.elem_ready     (elem_ready),
		.element_number (element_number),
		.node_a         (node_a),
		.node_b         (node_b),
		.node_c         (node_c),
		.node_d         (node_d),
		.element_kind   (element_kind),
		.last_of_cell   (last_of_cell),
		.bad_cell       (bad_cell)
	);

endmodule
